// ===== rtl/core/rfc_pkg.sv =====
// Shared types, constants and register codes for the reciprocal frequency counter.
// No dependencies; every other file in rtl/core imports this package.
package rfc_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CNT_W          = 24;
    localparam int CAP_W          = 16;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;
    localparam int DIVD_W         = 48;   // dividend: edges * ref_hz
    localparam int DIVS_W         = 25;   // divisor: elapsed + correction

    localparam logic [CNT_W-1:0] MAX24 = '1;

    localparam logic [15:0] GATE_RST = 16'd32000;
    localparam logic [7:0]  TOV_RST  = 8'd16;
    localparam logic [23:0] REFHZ_RST = 24'd1000000;
    localparam logic [7:0]  CAL_RST  = 8'd52;

    typedef enum logic [1:0] {
        REG_GATE   = 2'd0,
        REG_TOV    = 2'd1,
        REG_REF_HZ = 2'd2,
        REG_CAL    = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SYNC    = 2'd1,
        PH_MEASURE = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        B_IDLE   = 3'd0,
        B_CORR   = 3'd1,
        B_MUL    = 3'd2,
        B_QSTART = 3'd3,
        B_DIV    = 3'd4,
        B_OUT    = 3'd5
    } t_bstate;

    typedef struct packed {
        logic [15:0] gate;
        logic [7:0]  tov;
        logic [23:0] ref_hz;
        logic [7:0]  cal;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] edges;
        logic [CNT_W-1:0] elapsed;
        logic [CAP_W-1:0] capture;
        logic             timed_out;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/core/reciprocal_frequency_counter_top.sv =====
// Top level of the reciprocal frequency counter: APB register file, front end,
// job queue and divide back end. Depends on rfc_pkg, rfc_front, rfc_queue, rfc_back.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): one word per reference tick
//    (i_func = 0, i_edge_req = 1 when a signal edge falls on that tick) or a
//    start word (i_func = 1) that arms sync. The front end takes one word per
//    cycle; it stalls only while the two-entry job queue is full.
//  - Output channel (o_out_valid / i_out_stall): one word per measurement,
//    either the frequency or a timeout word (o_freq_hz 0, o_timed_out 1).
//  - A measurement's job passes through the queue to the back end. A timeout
//    word goes straight to o_out_valid; otherwise the serial divider (one
//    quotient bit per cycle, 48 bits) runs one pass for edges/cal_divisor,
//    skipped when cal_divisor is 0, and one for the final quotient.
//  - A held result blocks the back end only; the front keeps counting until
//    the queue fills, then stalls the input.
//  - Reset (synchronous, active low) returns the phase to idle, clears the
//    counters and queue, and loads gate 32000, timeout 16, ref_hz 1000000 and
//    cal_divisor 52. Registers: 0 gate, 4 timeout, 8 ref_hz, 12 cal_divisor.
module reciprocal_frequency_counter_top #(
    parameter int TIMER_BITS = rfc_pkg::TIMER_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // APB-style config port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rfc_pkg::ADDR_W-1:0] paddr,
    input  logic [rfc_pkg::DATA_W-1:0] pwdata,
    output logic [rfc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    // input words
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_func,
    input  logic                       i_edge_req,
    // result words
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [23:0]                o_freq_hz,
    output logic [15:0]                o_capture_time,
    output logic [23:0]                o_edge_count,
    output logic                       o_timed_out
);
    import rfc_pkg::*;

    t_cfg    r_cfg;
    t_reg    reg_sel;
    logic    wr_en;

    logic    job_push;
    t_job    job_in;
    t_job    job_head;
    logic    job_pop;
    t_q_stat q_stat;

    // ---- register file ----
    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate   <= GATE_RST;
            r_cfg.tov    <= TOV_RST;
            r_cfg.ref_hz <= REFHZ_RST;
            r_cfg.cal    <= CAL_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_GATE:   r_cfg.gate   <= pwdata[15:0];
                REG_TOV:    r_cfg.tov    <= pwdata[7:0];
                REG_REF_HZ: r_cfg.ref_hz <= pwdata[23:0];
                REG_CAL:    r_cfg.cal    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_GATE:   prdata = DATA_W'(r_cfg.gate);
            REG_TOV:    prdata = DATA_W'(r_cfg.tov);
            REG_REF_HZ: prdata = DATA_W'(r_cfg.ref_hz);
            REG_CAL:    prdata = DATA_W'(r_cfg.cal);
            default:    prdata = '0;
        endcase
    end

    // ---- front end: phases and counters ----
    rfc_front #(
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_edge_req (i_edge_req),
        .i_cfg      (r_cfg),
        .i_full     (q_stat.full),
        .o_in_stall (o_in_stall),
        .o_push     (job_push),
        .o_job      (job_in)
    );

    // ---- job queue ----
    rfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_head  (job_head),
        .o_stat  (q_stat)
    );

    // ---- back end: divide and result word ----
    rfc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (job_head),
        .i_q_valid      (!q_stat.empty),
        .o_pop          (job_pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_freq_hz      (o_freq_hz),
        .o_capture_time (o_capture_time),
        .o_edge_count   (o_edge_count),
        .o_timed_out    (o_timed_out)
    );

    // ---- assertions ----
    // an empty queue never stalls the input
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.empty |-> !o_in_stall)
        else $error("input stalled with empty job queue");

    // back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> !q_stat.empty)
        else $error("pop from empty job queue");

    // timeout words carry zero frequency
    a_tout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_timed_out) |-> (o_freq_hz == 24'd0))
        else $error("timeout word with nonzero frequency");

    // a computed result always follows at least one counted edge
    a_edges_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_timed_out) |-> (o_edge_count != 24'd0))
        else $error("frequency word with zero edge count");

endmodule

// ===== rtl/core/rfc_front.sv =====
// Front end: accepts tick/start words, runs the sync/measure phases and counters,
// and pushes one job per finished measurement. Depends on rfc_pkg.
module rfc_front #(
    parameter int TIMER_BITS = rfc_pkg::TIMER_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_func,
    input  logic          i_edge_req,
    input  rfc_pkg::t_cfg i_cfg,
    input  logic          i_full,
    output logic          o_in_stall,
    output logic          o_push,
    output rfc_pkg::t_job o_job
);
    import rfc_pkg::*;

    localparam int SPAN_W = 8 + TIMER_BITS;
    localparam int CMP_W  = (SPAN_W > CNT_W) ? SPAN_W : CNT_W;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_el, n_el;
    logic [CNT_W-1:0] r_edges, n_edges;
    logic [CAP_W-1:0] r_cap, n_cap;

    logic [CNT_W-1:0] el_adv;
    logic [CMP_W-1:0] span;
    logic             tout;
    logic             accept;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        el_adv = (r_el == MAX24) ? r_el : r_el + 1'b1;
        span   = CMP_W'({i_cfg.tov, {TIMER_BITS{1'b0}}});
        tout   = (el_adv == MAX24) || (CMP_W'(el_adv) >= span);

        n_phase = r_phase;
        n_el    = r_el;
        n_edges = r_edges;
        n_cap   = r_cap;
        o_push  = 1'b0;
        o_job   = '0;

        if (accept) begin
            if (i_func) begin
                n_phase = PH_SYNC;
                n_el    = '0;
                n_edges = '0;
                n_cap   = '0;
            end else begin
                case (r_phase)
                    PH_SYNC: begin
                        n_el = el_adv;
                        if (i_edge_req || tout) begin
                            n_el    = '0;
                            n_edges = '0;
                            n_cap   = '0;
                            n_phase = PH_MEASURE;
                        end
                    end
                    PH_MEASURE: begin
                        n_el = el_adv;
                        if (i_edge_req) begin
                            n_edges = (r_edges == MAX24) ? r_edges : r_edges + 1'b1;
                            n_cap   = el_adv[CAP_W-1:0];
                        end
                        o_job.edges     = n_edges;
                        o_job.elapsed   = el_adv;
                        o_job.capture   = n_cap;
                        o_job.timed_out = tout;
                        // timeout wins over a gated edge at the same tick
                        if (tout || (i_edge_req && (el_adv >= CNT_W'(i_cfg.gate)))) begin
                            o_push  = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    default: ;  // idle ticks are dropped
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_el    <= '0;
            r_edges <= '0;
            r_cap   <= '0;
        end else begin
            r_phase <= n_phase;
            r_el    <= n_el;
            r_edges <= n_edges;
            r_cap   <= n_cap;
        end
    end

endmodule

// ===== rtl/core/rfc_queue.sv =====
// Two-entry job queue between the front end and the divide back end.
// Depends on rfc_pkg.
module rfc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rfc_pkg::t_job    i_job,
    input  logic             i_pop,
    output rfc_pkg::t_job    o_head,
    output rfc_pkg::t_q_stat o_stat
);
    import rfc_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt, n_cnt;

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_comb begin
        n_cnt = r_cnt;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/rfc_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by both divide passes.
// Depends on rfc_pkg for the operand widths.
module rfc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rfc_pkg::DIVD_W-1:0] i_dividend,
    input  logic [rfc_pkg::DIVS_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [rfc_pkg::DIVD_W-1:0] o_quotient
);
    import rfc_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W);
    localparam logic [STEP_W-1:0] LAST = STEP_W'(DIVD_W - 1);

    logic              r_busy, r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIVS_W-1:0] r_rem, r_dvs;
    logic [DIVD_W-1:0] r_quo;

    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_comb begin
        trial = {r_rem, r_quo[DIVD_W-1]};
        ge    = (trial >= {1'b0, r_dvs});
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/rfc_back.sv =====
// Back end: pops jobs, computes edges*ref_hz/(elapsed + edges/cal) (no correction if cal 0;
// zero for a timeout) and holds the result word. Depends on rfc_pkg and rfc_div.
module rfc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rfc_pkg::t_cfg    i_cfg,
    input  rfc_pkg::t_job    i_head,
    input  logic             i_q_valid,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [23:0]      o_freq_hz,
    output logic [15:0]      o_capture_time,
    output logic [23:0]      o_edge_count,
    output logic             o_timed_out
);
    import rfc_pkg::*;

    t_bstate          r_state, n_state;
    t_job             r_job, n_job;
    logic [CNT_W-1:0] r_corr, n_corr;
    logic [DIVD_W-1:0] r_num, n_num;
    logic [DIVS_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_freq, n_freq;

    logic              div_start;
    logic [DIVD_W-1:0] div_dvd;
    logic [DIVS_W-1:0] div_dvs;
    logic              div_done;
    logic [DIVD_W-1:0] div_q;

    rfc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_out_valid    = (r_state == B_OUT);
    assign o_freq_hz      = r_freq;
    assign o_capture_time = r_job.capture;
    assign o_edge_count   = r_job.edges;
    assign o_timed_out    = r_job.timed_out;

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_corr    = r_corr;
        n_num     = r_num;
        n_den     = r_den;
        n_freq    = r_freq;
        o_pop     = 1'b0;
        div_start = 1'b0;
        div_dvd   = DIVD_W'(i_head.edges);
        div_dvs   = DIVS_W'(i_cfg.cal);

        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    n_job = i_head;
                    if (i_head.timed_out) begin
                        n_freq  = '0;
                        n_state = B_OUT;
                    end else if (i_cfg.cal == 8'd0) begin
                        n_corr  = '0;
                        n_state = B_MUL;
                    end else begin
                        div_start = 1'b1;
                        n_state   = B_CORR;
                    end
                end
            end
            B_CORR: begin
                if (div_done) begin
                    n_corr  = div_q[CNT_W-1:0];
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_num   = DIVD_W'(r_job.edges) * DIVD_W'(i_cfg.ref_hz);
                n_den   = {1'b0, r_job.elapsed} + {1'b0, r_corr};
                n_state = B_QSTART;
            end
            B_QSTART: begin
                div_dvd = r_num;
                div_dvs = r_den;
                if (r_den == '0) begin
                    n_freq  = MAX24;
                    n_state = B_OUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = B_DIV;
                end
            end
            B_DIV: begin
                if (div_done) begin
                    n_freq  = (|div_q[DIVD_W-1:CNT_W]) ? MAX24 : div_q[CNT_W-1:0];
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (!i_out_stall) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_corr <= n_corr;
        r_num  <= n_num;
        r_den  <= n_den;
        r_freq <= n_freq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for reciprocal_frequency_counter_top: register setup over APB,
// streams of tick/start words, and field-by-field checks of every reading.
// Depends on rfc_pkg and the RTL under rtl/core only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfc_pkg::*;

    // input word codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    // let the back end finish its reading before touching registers
    localparam int SETTLE_CYCLES = 160;
    localparam int PHASE_WORDS   = 320;

    typedef struct packed {
        logic [23:0] freq;
        logic [15:0] capture;
        logic [23:0] edges;
        logic        timed_out;
    } t_reading;

    typedef enum logic { ROW_WORD, ROW_CFG } t_row_kind;

    // one line of the directed table: either a word or a register write
    typedef struct packed {
        t_row_kind   kind;
        logic        func;
        logic        edge_bit;
        t_reg        reg_sel;
        logic [23:0] value;
        logic        has_want;
        t_reading    want;
    } t_dir_row;

    localparam t_reading NO_READING = '0;

    // Hand-checked walk through the special cases. Typed readings follow directly
    // from the formula with tiny counts; everything else goes through the predictor.
    localparam t_dir_row DIRECTED_ROWS [35] = '{
        // cal 0 drops the correction term, ref_hz at its top
        '{ROW_CFG,  FUNC_TICK,  1'b0, REG_GATE,   24'd2,        1'b0, NO_READING},
        '{ROW_CFG,  FUNC_TICK,  1'b0, REG_REF_HZ, 24'd16000000, 1'b0, NO_READING},
        '{ROW_CFG,  FUNC_TICK,  1'b0, REG_CAL,    24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_TICK,  1'b1, REG_GATE,   24'd0,        1'b0, NO_READING}, // idle: ignored
        '{ROW_WORD, FUNC_START, 1'b1, REG_GATE,   24'd0,        1'b0, NO_READING}, // edge ignored
        '{ROW_WORD, FUNC_TICK,  1'b0, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_TICK,  1'b1, REG_GATE,   24'd0,        1'b0, NO_READING}, // ends sync
        '{ROW_WORD, FUNC_TICK,  1'b1, REG_GATE,   24'd0,        1'b0, NO_READING}, // below gate
        '{ROW_WORD, FUNC_TICK,  1'b0, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_TICK,  1'b1, REG_GATE,   24'd0,        1'b1,
          '{24'd10666666, 16'd3, 24'd2, 1'b0}},
        // zero gate: first measured edge completes; cal 1 adds one tick per edge
        '{ROW_CFG,  FUNC_TICK,  1'b0, REG_CAL,    24'd1,        1'b0, NO_READING},
        '{ROW_CFG,  FUNC_TICK,  1'b0, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_START, 1'b0, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_TICK,  1'b1, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_TICK,  1'b1, REG_GATE,   24'd0,        1'b1,
          '{24'd8000000, 16'd1, 24'd1, 1'b0}},
        // zero timeout: sync and measure both expire on their first tick
        '{ROW_CFG,  FUNC_TICK,  1'b0, REG_TOV,    24'd0,        1'b0, NO_READING},
        '{ROW_CFG,  FUNC_TICK,  1'b0, REG_REF_HZ, 24'd1,        1'b0, NO_READING},
        '{ROW_CFG,  FUNC_TICK,  1'b0, REG_CAL,    24'd255,      1'b0, NO_READING},
        '{ROW_WORD, FUNC_START, 1'b0, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_TICK,  1'b0, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_TICK,  1'b1, REG_GATE,   24'd0,        1'b1,
          '{24'd0, 16'd1, 24'd1, 1'b1}},                                          // edge loses
        '{ROW_WORD, FUNC_START, 1'b0, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_TICK,  1'b0, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_TICK,  1'b0, REG_GATE,   24'd0,        1'b1,
          '{24'd0, 16'd0, 24'd0, 1'b1}},                                          // no edge
        // back near reset values; start in mid-measure restarts sync
        '{ROW_CFG,  FUNC_TICK,  1'b0, REG_TOV,    24'd16,       1'b0, NO_READING},
        '{ROW_CFG,  FUNC_TICK,  1'b0, REG_GATE,   24'd1,        1'b0, NO_READING},
        '{ROW_CFG,  FUNC_TICK,  1'b0, REG_REF_HZ, 24'd1000000,  1'b0, NO_READING},
        '{ROW_CFG,  FUNC_TICK,  1'b0, REG_CAL,    24'd52,       1'b0, NO_READING},
        '{ROW_WORD, FUNC_START, 1'b0, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_TICK,  1'b1, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_TICK,  1'b0, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_START, 1'b1, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_TICK,  1'b0, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_TICK,  1'b1, REG_GATE,   24'd0,        1'b0, NO_READING},
        '{ROW_WORD, FUNC_TICK,  1'b1, REG_GATE,   24'd0,        1'b1,
          '{24'd1000000, 16'd1, 24'd1, 1'b0}}
    };

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [ADDR_W-1:0]   paddr      = '0;
    logic [DATA_W-1:0]   pwdata     = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_func     = 1'b0;
    logic                i_edge_req = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [23:0]         o_freq_hz;
    logic [15:0]         o_capture_time;
    logic [23:0]         o_edge_count;
    logic                o_timed_out;

    reciprocal_frequency_counter_top dut (.*);

    // predictor copy of the registers and counter state
    logic [15:0] cfg_gate   = GATE_RST;
    logic [7:0]  cfg_tov    = TOV_RST;
    logic [23:0] cfg_ref_hz = REFHZ_RST;
    logic [7:0]  cfg_cal    = CAL_RST;
    t_phase      meas_phase = PH_IDLE;
    logic [23:0] elapsed_ct = '0;
    logic [23:0] edge_ct    = '0;
    logic [15:0] capture_lo = '0;

    t_reading pending_readings [$];
    t_reading head;

    int fails         = 0;
    int words_sent    = 0;
    int readings_seen = 0;
    int timeouts_seen = 0;
    int cfg_writes    = 0;
    int tx_idle_pct   = 35;
    int rx_idle_pct   = 82;

    always #1 i_clk = ~i_clk;

    // receiver side: random stall each cycle at the current rate
    always @(posedge i_clk) i_out_stall <= ($urandom_range(99) < rx_idle_pct);

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        fails++;
        if (fails <= 100)
            $display("%0t: mismatch on %s, expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // ---------------------------------------------------------------- predictor

    // expires once elapsed reaches tov * 2^TIMER_BITS, or on saturation
    function automatic logic timeout_due();
        logic [63:0] span;
        span = 64'(cfg_tov) << TIMER_BITS_DEF;
        return elapsed_ct == MAX24 || 64'(elapsed_ct) >= span;
    endfunction

    function automatic void clear_counts();
        elapsed_ct = '0;
        edge_ct    = '0;
        capture_lo = '0;
    endfunction

    // Advances the counter state by one word; returns 1 when the word closes a
    // measurement, with the reading in r.
    function automatic logic predict_word(input logic func, input logic edge_bit,
                                          output t_reading r);
        logic [63:0] num, corr, den, quo;
        logic        gated;
        r     = '0;
        gated = 1'b0;
        if (func == FUNC_START) begin
            meas_phase = PH_SYNC;
            clear_counts();
            return 1'b0;
        end
        if (meas_phase != PH_SYNC && meas_phase != PH_MEASURE)
            return 1'b0;
        // tick first, then the edge latches the advanced count
        if (elapsed_ct != MAX24)
            elapsed_ct = elapsed_ct + 24'd1;
        if (meas_phase == PH_SYNC) begin
            // sync end: edge is not counted, window starts from zero
            if (edge_bit || timeout_due()) begin
                clear_counts();
                meas_phase = PH_MEASURE;
            end
            return 1'b0;
        end
        if (edge_bit) begin
            if (edge_ct != MAX24)
                edge_ct = edge_ct + 24'd1;
            capture_lo = elapsed_ct[15:0];
            gated      = elapsed_ct >= 24'(cfg_gate);
        end
        r.capture = capture_lo;
        r.edges   = edge_ct;
        // a timeout on the same tick as a gated edge still wins
        if (timeout_due()) begin
            r.timed_out = 1'b1;
            meas_phase  = PH_IDLE;
            return 1'b1;
        end
        if (!gated)
            return 1'b0;
        num  = 64'(edge_ct) * 64'(cfg_ref_hz);
        corr = (cfg_cal != 8'd0) ? 64'(edge_ct / 24'(cfg_cal)) : 64'd0;
        den  = 64'(elapsed_ct) + corr;     // elapsed is at least 1 at any edge
        quo  = num / den;
        r.freq     = (quo > 64'(MAX24)) ? MAX24 : quo[23:0];
        meas_phase = PH_IDLE;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- drivers

    // Presents one word and holds it until taken. The prediction is pushed at
    // the accepting edge, so a reading can never overtake its expectation.
    task automatic send_word(input logic func, input logic edge_bit,
                             input logic has_want = 1'b0, input t_reading want = '0);
        t_reading r;
        logic     closes;
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_edge_req <= edge_bit;
        do @(posedge i_clk); while (o_in_stall);
        if (!(func == FUNC_TICK && meas_phase == PH_IDLE))
            words_sent++;
        closes = predict_word(func, edge_bit, r);
        if (has_want)
            pending_readings.push_back(want);
        else if (closes)
            pending_readings.push_back(r);
        // sender gap, geometric length; payload is junk while valid is low
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            i_func     <= 1'($urandom_range(1));
            i_edge_req <= 1'($urandom_range(1));
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // always spends at least one edge, so valid never drops and rises in one step
    task automatic drain_readings();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_readings.size() != 0);
    endtask

    // a word may have started a measurement with no reading yet; let the back end finish
    task automatic settle();
        drain_readings();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_reg(input t_reg idx, input logic [31:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (got !== want)
            note_mismatch($sformatf("readback of register %s", idx.name()), want, got);
    endtask

    task automatic write_reg(input t_reg idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // register takes the value at this edge
        case (idx)
            REG_GATE:   cfg_gate   = value[15:0];
            REG_TOV:    cfg_tov    = value[7:0];
            REG_REF_HZ: cfg_ref_hz = value[23:0];
            REG_CAL:    cfg_cal    = value[7:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
        check_reg(idx, value);
    endtask

    // Register setting per random phase: random for phases 0, 4 and 5, extremes for 1 to 3.
    task automatic program_phase(input int ph);
        logic [15:0] gate;
        logic [7:0]  tov;
        logic [23:0] hz;
        logic [7:0]  cal;
        gate = 16'($urandom_range(48, 1));
        tov  = 8'($urandom_range(255, 1));
        hz   = 24'($urandom_range(16000000, 1));
        cal  = 8'($urandom_range(255, 0));
        case (ph)
            1: begin
                gate = 16'd0;
                tov  = 8'd255;
                hz   = 24'd16000000;
                cal  = 8'd255;
            end
            2: begin
                tov = 8'd1;
                hz  = 24'd1;
                cal = 8'd0;
            end
            3: begin
                tov = 8'd0;     // every window times out at once
                cal = 8'd1;
            end
            default: ;
        endcase
        settle();
        write_reg(REG_GATE, 32'(gate));
        write_reg(REG_TOV, 32'(tov));
        write_reg(REG_REF_HZ, 32'(hz));
        write_reg(REG_CAL, 32'(cal));
    endtask

    // Mostly complete measurements with random edge density; some stray ticks
    // and some aborted windows (restart or junk words in the middle).
    task automatic run_sequence();
        int pick;
        int density;
        int guard;
        pick = $urandom_range(99);
        if (pick < 6) begin
            send_word(FUNC_TICK, 1'($urandom_range(1)));
        end else if (pick < 18) begin
            send_word(FUNC_START, 1'($urandom_range(1)));
            repeat ($urandom_range(6, 1))
                send_word(($urandom_range(7) == 0) ? FUNC_START : FUNC_TICK,
                          1'($urandom_range(1)));
        end else begin
            send_word(FUNC_START, 1'($urandom_range(1)));
            repeat ($urandom_range(3))
                send_word(FUNC_TICK, 1'b0);
            send_word(FUNC_TICK, 1'b1);            // closes sync
            density = $urandom_range(100, 15);
            guard   = 0;
            while (meas_phase != PH_IDLE && guard < 300) begin
                send_word(FUNC_TICK, $urandom_range(99) < density);
                guard++;
            end
        end
    endtask

    // ---------------------------------------------------------------- checker

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_readings.size() == 0) begin
                note_mismatch("unexpected reading, freq_hz", 32'd0, 32'(o_freq_hz));
            end else begin
                head = pending_readings.pop_front();
                readings_seen++;
                if (head.timed_out)
                    timeouts_seen++;
                if (o_freq_hz !== head.freq)
                    note_mismatch("freq_hz", 32'(head.freq), 32'(o_freq_hz));
                if (o_capture_time !== head.capture)
                    note_mismatch("capture_time", 32'(head.capture), 32'(o_capture_time));
                if (o_edge_count !== head.edges)
                    note_mismatch("edge_count", 32'(head.edges), 32'(o_edge_count));
                if (o_timed_out !== head.timed_out)
                    note_mismatch("timed_out", 32'(head.timed_out), 32'(o_timed_out));
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin : stimulus
        int   ph;
        int   phase_start;
        logic held;
        held = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of all registers
        check_reg(REG_GATE, 32'(GATE_RST));
        check_reg(REG_TOV, 32'(TOV_RST));
        check_reg(REG_REF_HZ, 32'(REFHZ_RST));
        check_reg(REG_CAL, 32'(CAL_RST));

        foreach (DIRECTED_ROWS[n]) begin
            if (DIRECTED_ROWS[n].kind == ROW_CFG) begin
                settle();
                write_reg(DIRECTED_ROWS[n].reg_sel, 32'(DIRECTED_ROWS[n].value));
            end else begin
                send_word(DIRECTED_ROWS[n].func, DIRECTED_ROWS[n].edge_bit,
                          DIRECTED_ROWS[n].has_want, DIRECTED_ROWS[n].want);
            end
        end

        // idle mix: sender light / receiver heavy, then swapped, then none
        for (ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                tx_idle_pct = 82;
                rx_idle_pct = 35;
            end
            if (ph == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            program_phase(ph);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                run_sequence();
                // hold the sender once until the output side has caught up
                if (ph == 1 && !held && words_sent - phase_start >= PHASE_WORDS / 2) begin
                    drain_readings();
                    held = 1'b1;
                end
            end
        end

        drain_readings();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d counted words, %0d readings (%0d of them timeouts), %0d writes",
                 words_sent, readings_seen, timeouts_seen, cfg_writes);
        $display("Register settings included zero gate, zero timeout, zero cal and extremes");
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rfc_pkg.sv
rtl/core/rfc_front.sv
rtl/core/rfc_queue.sv
rtl/core/rfc_div.sv
rtl/core/rfc_back.sv
rtl/core/reciprocal_frequency_counter_top.sv
verif/tb.sv
